// ----- rtl/core/tpmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmd_pkg: shared types and constants
// Widths, register indexes, sequencer states and the multiplier control
// bundle of the three-axis PID motor drive.
// ----------------------------------------------------------------------------
package tpmd_pkg;

	localparam int AXES      = 3;
	localparam int AXIS_W    = 2;
	localparam int MODE_W    = 2;
	localparam int FRAC_BITS = 16;

	localparam int ANG_W    = 32;
	localparam int ERR_W    = 32;
	localparam int INTEG_W  = 48;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int DV_W     = 49;
	localparam int ENT_W    = ERR_W + INTEG_W + 1;

	// shared multiplier: 33b signed x 25b signed
	localparam int OPA_W    = 33;
	localparam int OPB_W    = 25;
	localparam int LO_W     = OPB_W - 1;
	localparam int MUL_W    = OPA_W + OPB_W;
	localparam int PROD_W   = ANG_W + DV_W;
	localparam int TERM_W   = 48;
	localparam int U_W      = TERM_W + 2;
	localparam int MAG_W    = U_W - 1;

	localparam int CLAMP_W    = 15;
	localparam int SPEED_W    = 8;
	localparam int STEP_W     = 16;
	localparam int STEP_FRAC  = 16;
	localparam int DSCALE_W   = 16;
	localparam int CMD_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int MODE_I_BIT = 0;
	localparam int MODE_D_BIT = 1;

	localparam logic [AXIS_W-1:0] AX_0 = AXIS_W'(0);
	localparam logic [AXIS_W-1:0] AX_1 = AXIS_W'(1);
	localparam logic [AXIS_W-1:0] AX_2 = AXIS_W'(2);
	localparam logic [AXIS_W-1:0] MIN_SPEED_AXIS = AX_2;

	localparam logic [CLAMP_W-1:0]  RST_CLAMP0  = CLAMP_W'(32);
	localparam logic [CLAMP_W-1:0]  RST_CLAMP1  = CLAMP_W'(40);
	localparam logic [CLAMP_W-1:0]  RST_CLAMP2  = CLAMP_W'(7);
	localparam logic [SPEED_W-1:0]  RST_MAX_SPD = SPEED_W'(100);
	localparam logic [SPEED_W-1:0]  RST_MIN_SPD = SPEED_W'(8);
	localparam logic [STEP_W-1:0]   RST_STEP    = STEP_W'(655);
	localparam logic [DSCALE_W-1:0] RST_DSCALE  = DSCALE_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLAMP0,
		REG_CLAMP1,
		REG_CLAMP2,
		REG_MAX_SPEED,
		REG_MIN_SPEED2,
		REG_INTEG_STEP,
		REG_DERIV_SCALE
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_INC,
		ST_DV,
		ST_PH,
		ST_IL,
		ST_IH,
		ST_DL,
		ST_DH,
		ST_DP,
		ST_DSUM,
		ST_ABS,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic ld_lo;
		logic ld_prod;
	} mac_ctl_t;

endpackage

// ----- rtl/core/tpmd_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmd_mac: shared multiplier and gain-term assembly
// Registered 33x25 multiply. A gain term is built from a low and a high
// partial product, floored by FRAC_BITS and saturated to +-(2^47-1).
// ----------------------------------------------------------------------------
module tpmd_mac (
	input  logic                               clk,
	input  tpmd_pkg::mac_ctl_t                 ctl,
	input  logic signed [tpmd_pkg::OPA_W-1:0]  op_a,
	input  logic signed [tpmd_pkg::OPB_W-1:0]  op_b,
	output logic signed [tpmd_pkg::MUL_W-1:0]  product,
	output logic signed [tpmd_pkg::TERM_W-1:0] term
);
	import tpmd_pkg::*;

	localparam int Q_W = PROD_W - FRAC_BITS;
	localparam logic signed [Q_W-1:0] Q_HI = {{(Q_W-TERM_W+1){1'b0}}, {(TERM_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_LO = -Q_HI;
	localparam logic signed [TERM_W-1:0] T_HI = {1'b0, {(TERM_W-1){1'b1}}};
	localparam logic signed [TERM_W-1:0] T_LO = -T_HI;

	logic signed [MUL_W-1:0]  mul_q;
	logic signed [MUL_W-1:0]  lo_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [Q_W-1:0]    quo;

	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
		if (ctl.ld_lo) begin
			lo_q <= mul_q;
		end
		if (ctl.ld_prod) begin
			prod_q <= (PROD_W'(mul_q) <<< LO_W) + PROD_W'(lo_q);
		end
	end

	// floor(prod / 2^F): arithmetic part-select
	assign quo     = prod_q[PROD_W-1:FRAC_BITS];
	assign product = mul_q;

	always_comb begin
		if (quo > Q_HI) begin
			term = T_HI;
		end else if (quo < Q_LO) begin
			term = T_LO;
		end else begin
			term = quo[TERM_W-1:0];
		end
	end

endmodule

// ----- rtl/core/three_axis_pid_motor_drive_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_pid_motor_drive_top: three-axis PID controller, motor command
// Fixed-point PID with clamping anti-windup and per-axis state in a RAM.
//
// Each input beat names an axis, a mode (P, PI, PD, PID), target and measured
// angles and the three gains, all signed Q16.16; each beat yields exactly one
// output beat with the signed motor command and the axis's new freeze flag.
// Items are handled one at a time. A result is built with the one shared
// 33x25 multiplier, which runs eight products in sequence (integral
// increment, derivative difference, then low and high halves of the three
// gain terms), and lands in the output register when the sequencer leaves
// its output state; the sequencer then returns to idle before it takes the
// next item. An item with axis 3 bypasses the arithmetic and its zero
// command goes straight from acceptance to the output state. A result that
// finds the output register still full and not being taken waits, and the
// input stalls with it. in_ready is high while the sequencer is idle, also
// when a finished result still waits in the output register; the next
// result waits there only if that beat has not been taken. Per-axis previous
// error, integral and freeze flag live in a small RAM read at acceptance and
// written back when the result is issued, so successive items on the same
// axis never overlap. Valid bits, cleared by reset, make every axis read as
// zero state until first written. Configuration writes take effect for items
// accepted after the write; an item still in progress also sees them.
// ----------------------------------------------------------------------------
module three_axis_pid_motor_drive_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [tpmd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tpmd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [tpmd_pkg::AXIS_W-1:0]           axis,
	input  logic [tpmd_pkg::MODE_W-1:0]           mode,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     target_angle,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     measured_angle,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     gain_p,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     gain_i,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     gain_d,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [tpmd_pkg::CMD_W-1:0]     motor_command,
	output logic                                  integrator_frozen
);
	import tpmd_pkg::*;

	localparam logic signed [ERR_W-1:0]   E_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0]   E_MIN = {1'b1, {(ERR_W-1){1'b0}}};
	localparam logic signed [INTEG_W-1:0] I_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] I_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam int LIM_W = CLAMP_W + FRAC_BITS;
	localparam int SPD_RAW_W = MAG_W - FRAC_BITS;

	// ---------------- configuration registers ----------------
	logic [CLAMP_W-1:0]  clamp0_q, clamp1_q, clamp2_q;
	logic [SPEED_W-1:0]  max_spd_q, min_spd_q;
	logic [STEP_W-1:0]   step_q;
	logic [DSCALE_W-1:0] dscale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp0_q  <= RST_CLAMP0;
			clamp1_q  <= RST_CLAMP1;
			clamp2_q  <= RST_CLAMP2;
			max_spd_q <= RST_MAX_SPD;
			min_spd_q <= RST_MIN_SPD;
			step_q    <= RST_STEP;
			dscale_q  <= RST_DSCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLAMP0:      clamp0_q  <= cfg_wdata[CLAMP_W-1:0];
				REG_CLAMP1:      clamp1_q  <= cfg_wdata[CLAMP_W-1:0];
				REG_CLAMP2:      clamp2_q  <= cfg_wdata[CLAMP_W-1:0];
				REG_MAX_SPEED:   max_spd_q <= cfg_wdata[SPEED_W-1:0];
				REG_MIN_SPEED2:  min_spd_q <= cfg_wdata[SPEED_W-1:0];
				REG_INTEG_STEP:  step_q    <= cfg_wdata[STEP_W-1:0];
				REG_DERIV_SCALE: dscale_q  <= cfg_wdata[DSCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	state_t state_q, state_nx;
	logic   accept, axis_ok, fire, out_free, mem_we;
	logic   out_valid_q;
	mac_ctl_t mac_ctl;

	assign axis_ok  = axis < AXIS_W'(AXES);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = axis_ok ? ST_RD : ST_OUT;
				end
			end
			ST_RD:   state_nx = ST_INC;
			ST_INC:  state_nx = ST_DV;
			ST_DV:   state_nx = ST_PH;
			ST_PH:   state_nx = ST_IL;
			ST_IL:   state_nx = ST_IH;
			ST_IH:   state_nx = ST_DL;
			ST_DL:   state_nx = ST_DH;
			ST_DH:   state_nx = ST_DP;
			ST_DP:   state_nx = ST_DSUM;
			ST_DSUM: state_nx = ST_ABS;
			ST_ABS:  state_nx = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ---------------- captured item ----------------
	logic [AXIS_W-1:0]       axis_q;
	logic [MODE_W-1:0]       mode_q;
	logic signed [ANG_W-1:0] kp_q, ki_q, kd_q;
	logic signed [ERR_W-1:0] e_q;
	logic                    bad_q;
	logic signed [DIFF_W-1:0] ang_diff;
	logic signed [ERR_W-1:0]  e_sat;

	assign ang_diff = DIFF_W'(target_angle) - DIFF_W'(measured_angle);

	always_comb begin
		if (ang_diff[DIFF_W-1] != ang_diff[DIFF_W-2]) begin
			e_sat = ang_diff[DIFF_W-1] ? E_MIN : E_MAX;
		end else begin
			e_sat = ang_diff[ERR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q <= axis;
			mode_q <= mode;
			kp_q   <= gain_p;
			ki_q   <= gain_i;
			kd_q   <= gain_d;
			e_q    <= e_sat;
			bad_q  <= !axis_ok;
		end
	end

	// ---------------- per-axis state RAM ----------------
	logic [ENT_W-1:0] mem [AXES];
	logic [ENT_W-1:0] rd_q, wr_data, cur;
	logic [AXES-1:0]  vld_q;
	logic             rd_vld_q;
	logic signed [ERR_W-1:0]   prev_err;
	logic signed [INTEG_W-1:0] integ_old, integ_new_q;
	logic                      flag_old;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[axis_q] <= wr_data;
		end
		if (accept && axis_ok) begin
			rd_q <= mem[axis];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[axis_q] <= 1'b1;
			end
			if (accept && axis_ok) begin
				rd_vld_q <= vld_q[axis];
			end
		end
	end

	// never-written axis reads as zero state
	assign cur       = rd_vld_q ? rd_q : '0;
	assign prev_err  = cur[ERR_W-1:0];
	assign integ_old = cur[ERR_W +: INTEG_W];
	assign flag_old  = cur[ENT_W-1];

	logic use_i, use_d;
	assign use_i = mode_q[MODE_I_BIT] && !flag_old;
	assign use_d = mode_q[MODE_D_BIT];

	// ---------------- multiplier operands ----------------
	logic signed [OPA_W-1:0]  op_a;
	logic signed [OPB_W-1:0]  op_b;
	logic signed [MUL_W-1:0]  mul_p;
	logic signed [TERM_W-1:0] term;
	logic signed [DV_W-1:0]   e_ext, i_ext, dv_q;

	assign e_ext = DV_W'(e_q);
	assign i_ext = DV_W'(integ_new_q);

	always_comb begin
		op_a    = '0;
		op_b    = '0;
		mac_ctl = '0;
		case (state_q)
			ST_RD: begin
				op_a = OPA_W'(e_q);
				op_b = {{(OPB_W-STEP_W){1'b0}}, step_q};
			end
			ST_INC: begin
				op_a = OPA_W'(e_q) - OPA_W'(prev_err);
				op_b = {{(OPB_W-DSCALE_W){1'b0}}, dscale_q};
			end
			ST_DV: begin
				op_a = OPA_W'(kp_q);
				op_b = {1'b0, e_ext[LO_W-1:0]};
			end
			ST_PH: begin
				op_a = OPA_W'(kp_q);
				op_b = e_ext[DV_W-1:LO_W];
				mac_ctl.ld_lo = 1'b1;
			end
			ST_IL: begin
				op_a = OPA_W'(ki_q);
				op_b = {1'b0, i_ext[LO_W-1:0]};
				mac_ctl.ld_prod = 1'b1;
			end
			ST_IH: begin
				op_a = OPA_W'(ki_q);
				op_b = i_ext[DV_W-1:LO_W];
				mac_ctl.ld_lo = 1'b1;
			end
			ST_DL: begin
				op_a = OPA_W'(kd_q);
				op_b = {1'b0, dv_q[LO_W-1:0]};
				mac_ctl.ld_prod = 1'b1;
			end
			ST_DH: begin
				op_a = OPA_W'(kd_q);
				op_b = dv_q[DV_W-1:LO_W];
				mac_ctl.ld_lo = 1'b1;
			end
			ST_DP: begin
				mac_ctl.ld_prod = 1'b1;
			end
			default: ;
		endcase
	end

	tpmd_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.op_a    (op_a),
		.op_b    (op_b),
		.product (mul_p),
		.term    (term)
	);

	// ---------------- integral and derivative ----------------
	logic signed [ERR_W:0]   inc;
	logic signed [INTEG_W:0] isum;

	// floor(e * step / 2^16)
	assign inc  = mul_p[STEP_FRAC +: ERR_W+1];
	assign isum = (INTEG_W+1)'(integ_old) + (INTEG_W+1)'(inc);

	always_ff @(posedge clk) begin
		if (state_q == ST_INC) begin
			if (isum[INTEG_W] != isum[INTEG_W-1]) begin
				integ_new_q <= isum[INTEG_W] ? I_MIN : I_MAX;
			end else begin
				integ_new_q <= isum[INTEG_W-1:0];
			end
		end
		if (state_q == ST_DV) begin
			dv_q <= mul_p[DV_W-1:0];
		end
	end

	// ---------------- control value ----------------
	logic signed [U_W-1:0] u_q;
	logic [MAG_W-1:0]      umag_q;
	logic                  uneg_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IH: u_q <= U_W'(term);
			ST_DH: begin
				if (use_i) begin
					u_q <= u_q + U_W'(term);
				end
			end
			ST_DSUM: begin
				if (use_d) begin
					u_q <= u_q + U_W'(term);
				end
			end
			ST_ABS: begin
				uneg_q <= u_q[U_W-1];
				umag_q <= u_q[U_W-1] ? MAG_W'(-u_q) : MAG_W'(u_q);
			end
			default: ;
		endcase
	end

	// ---------------- freeze flag and speed ----------------
	logic [CLAMP_W-1:0]   lim_sel;
	logic [LIM_W-1:0]     lim;
	logic [SPD_RAW_W-1:0] spd_raw;
	logic [SPEED_W-1:0]   spd_cap, spd;
	logic                 frozen, frozen_o;
	logic signed [CMD_W-1:0] cmd;

	always_comb begin
		case (axis_q)
			AX_0:    lim_sel = clamp0_q;
			AX_1:    lim_sel = clamp1_q;
			AX_2:    lim_sel = clamp2_q;
			default: lim_sel = '0;
		endcase
	end

	assign lim     = {lim_sel, {FRAC_BITS{1'b0}}};
	assign frozen  = (uneg_q == e_q[ERR_W-1]) && (umag_q > MAG_W'(lim));
	assign spd_raw = umag_q[MAG_W-1:FRAC_BITS];
	assign spd_cap = (spd_raw > SPD_RAW_W'(max_spd_q)) ? max_spd_q : spd_raw[SPEED_W-1:0];

	always_comb begin
		spd = spd_cap;
		if (axis_q == MIN_SPEED_AXIS && spd_cap < min_spd_q) begin
			spd = min_spd_q;
		end
		// motor turns against the control value
		if (bad_q) begin
			cmd      = '0;
			frozen_o = 1'b0;
		end else begin
			cmd      = uneg_q ? $signed({1'b0, spd}) : -$signed({1'b0, spd});
			frozen_o = frozen;
		end
	end

	assign fire    = (state_q == ST_OUT) && out_free;
	assign mem_we  = fire && !bad_q;
	assign wr_data = {frozen, (use_i ? integ_new_q : integ_old), e_q};

	// ---------------- output register ----------------
	logic signed [CMD_W-1:0] cmd_q;
	logic                    frz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cmd_q <= cmd;
			frz_q <= frozen_o;
		end
	end

	assign in_ready          = (state_q == ST_IDLE);
	assign out_valid         = out_valid_q;
	assign motor_command     = cmd_q;
	assign integrator_frozen = frz_q;

endmodule

// ----- tb/pid_drive_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_drive_checker: result checker for the three-axis PID motor drive
// Watches the config port and both channels, keeps its own copy of the axis
// state and registers, predicts each motor command beat and compares it.
// ----------------------------------------------------------------------------
module pid_drive_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tpmd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tpmd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [tpmd_pkg::AXIS_W-1:0]           axis,
	input  logic [tpmd_pkg::MODE_W-1:0]           mode,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     target_angle,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     measured_angle,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     gain_p,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     gain_i,
	input  logic signed [tpmd_pkg::ANG_W-1:0]     gain_d,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [tpmd_pkg::CMD_W-1:0]     motor_command,
	input  logic                                  integrator_frozen,
	output int                                    fail_cnt,
	output int                                    pending
);
	import tpmd_pkg::*;

	localparam longint TERM_LIM  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint INTEG_MAX = TERM_LIM;
	localparam longint INTEG_MIN = -TERM_LIM - 1;
	localparam longint ERR_MAX   = 64'sh0000_0000_7FFF_FFFF;
	localparam longint ERR_MIN   = -ERR_MAX - 1;
	localparam int     SHOW_MAX  = 10;

	typedef struct packed {
		logic signed [CMD_W-1:0] cmd;
		logic                    frozen;
	} drive_out_t;

	// shadow registers
	logic [CLAMP_W-1:0]  clamp_lim [AXES];
	logic [SPEED_W-1:0]  max_spd;
	logic [SPEED_W-1:0]  min_spd2;
	logic [STEP_W-1:0]   integ_step;
	logic [DSCALE_W-1:0] deriv_scale;

	// shadow axis state
	longint prev_err  [AXES];
	longint integ_acc [AXES];
	bit     freeze    [AXES];

	drive_out_t cmd_expect_q[$];
	drive_out_t want;
	drive_out_t got;
	int         beat_no;

	// floor(a * b / 2^F), clipped symmetrically to the term limit
	function automatic longint gain_term(input longint a, input longint b);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] p;
		wa = 128'(a);
		wb = 128'(b);
		p = (wa * wb) >>> FRAC_BITS;
		if (p > TERM_LIM)
			return TERM_LIM;
		if (p < -TERM_LIM)
			return -TERM_LIM;
		return p[63:0];
	endfunction

	function automatic drive_out_t predict_motor_cmd(
		input logic [AXIS_W-1:0]     ax,
		input logic [MODE_W-1:0]     md,
		input logic signed [ANG_W-1:0] tgt,
		input logic signed [ANG_W-1:0] msr,
		input logic signed [ANG_W-1:0] kp,
		input logic signed [ANG_W-1:0] ki,
		input logic signed [ANG_W-1:0] kd
	);
		drive_out_t r;
		longint     e;
		longint     u;
		longint     inc;
		longint     dv;
		longint     lim;
		longint     speed;
		bit         frz;
		r.cmd = '0;
		r.frozen = 1'b0;
		if (ax >= AXIS_W'(AXES))
			return r;

		e = longint'(tgt) - longint'(msr);
		if (e > ERR_MAX)
			e = ERR_MAX;
		if (e < ERR_MIN)
			e = ERR_MIN;
		u = gain_term(longint'(kp), e);

		// integral runs only while the axis is not frozen
		if (md[MODE_I_BIT] && !freeze[ax]) begin
			inc = (e * longint'(integ_step)) >>> STEP_FRAC;
			integ_acc[ax] = integ_acc[ax] + inc;
			if (integ_acc[ax] > INTEG_MAX)
				integ_acc[ax] = INTEG_MAX;
			if (integ_acc[ax] < INTEG_MIN)
				integ_acc[ax] = INTEG_MIN;
			u = u + gain_term(longint'(ki), integ_acc[ax]);
		end
		if (md[MODE_D_BIT]) begin
			dv = (e - prev_err[ax]) * longint'(deriv_scale);
			u = u + gain_term(longint'(kd), dv);
		end
		prev_err[ax] = e;

		// zero error counts as positive for the sign match
		lim = longint'(clamp_lim[ax]) <<< FRAC_BITS;
		frz = ((u < 0) == (e < 0)) && (u > lim || u < -lim);
		freeze[ax] = frz;

		speed = ((u < 0) ? -u : u) >>> FRAC_BITS;
		if (speed > longint'(max_spd))
			speed = longint'(max_spd);
		if (ax == MIN_SPEED_AXIS && speed < longint'(min_spd2))
			speed = longint'(min_spd2);

		r.cmd = CMD_W'((u < 0) ? speed : -speed);
		r.frozen = frz;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_lim[AX_0] = RST_CLAMP0;
			clamp_lim[AX_1] = RST_CLAMP1;
			clamp_lim[AX_2] = RST_CLAMP2;
			max_spd = RST_MAX_SPD;
			min_spd2 = RST_MIN_SPD;
			integ_step = RST_STEP;
			deriv_scale = RST_DSCALE;
			for (int i = 0; i < AXES; i++) begin
				prev_err[i] = 0;
				integ_acc[i] = 0;
				freeze[i] = 1'b0;
			end
			cmd_expect_q.delete();
			fail_cnt = 0;
			pending = 0;
			beat_no = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CLAMP0:      clamp_lim[AX_0] = cfg_wdata[CLAMP_W-1:0];
					REG_CLAMP1:      clamp_lim[AX_1] = cfg_wdata[CLAMP_W-1:0];
					REG_CLAMP2:      clamp_lim[AX_2] = cfg_wdata[CLAMP_W-1:0];
					REG_MAX_SPEED:   max_spd = cfg_wdata[SPEED_W-1:0];
					REG_MIN_SPEED2:  min_spd2 = cfg_wdata[SPEED_W-1:0];
					REG_INTEG_STEP:  integ_step = cfg_wdata[STEP_W-1:0];
					REG_DERIV_SCALE: deriv_scale = cfg_wdata[DSCALE_W-1:0];
					default: ;
				endcase
			end

			// result side first: a beat leaving now belongs to an older item
			if (out_valid && out_ready) begin
				got.cmd = motor_command;
				got.frozen = integrator_frozen;
				if (cmd_expect_q.size() == 0) begin
					if (fail_cnt < SHOW_MAX)
						$display("%0t: result beat %0d with nothing expected (cmd %0d frz %0b)",
							$time, beat_no, got.cmd, got.frozen);
					fail_cnt++;
				end else begin
					want = cmd_expect_q.pop_front();
					if (got !== want) begin
						if (fail_cnt < SHOW_MAX)
							$display("%0t: beat %0d cmd exp %0d got %0d, frz exp %0b got %0b",
								$time, beat_no, want.cmd, got.cmd, want.frozen, got.frozen);
						fail_cnt++;
					end
				end
				beat_no++;
			end

			if (in_valid && in_ready)
				cmd_expect_q.push_back(predict_motor_cmd(axis, mode, target_angle,
					measured_angle, gain_p, gain_i, gain_d));

			pending = cmd_expect_q.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the three-axis PID motor drive
// Directed control requests at reset settings, then random requests over
// several register settings with bursty input and a stalling receiver.
// Prediction and comparison live in pid_drive_checker.
// ----------------------------------------------------------------------------
module tb;
	import tpmd_pkg::*;

	// one item at a time; 1k items with gaps and stalls fit easily
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 24;

	localparam logic [MODE_W-1:0]    MODE_P   = 2'd0;
	localparam logic [MODE_W-1:0]    MODE_PI  = 2'd1;
	localparam logic [MODE_W-1:0]    MODE_PD  = 2'd2;
	localparam logic [MODE_W-1:0]    MODE_PID = 2'd3;
	localparam logic [AXIS_W-1:0]    AX_NONE    = 2'd3;   // no such axis, zero result
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // write must be dropped

	// handy Q16.16 values
	localparam logic signed [ANG_W-1:0] Q_ZERO = 32'sh0000_0000;
	localparam logic signed [ANG_W-1:0] Q_LSB  = 32'sh0000_0001;
	localparam logic signed [ANG_W-1:0] Q_MLSB = 32'shFFFF_FFFF;
	localparam logic signed [ANG_W-1:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [ANG_W-1:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [ANG_W-1:0] Q_TWO  = 32'sh0002_0000;
	localparam logic signed [ANG_W-1:0] Q_FIVE = 32'sh0005_0000;
	localparam logic signed [ANG_W-1:0] Q_TEN  = 32'sh000A_0000;
	localparam logic signed [ANG_W-1:0] Q_40   = 32'sh0028_0000;
	localparam logic signed [ANG_W-1:0] Q_100  = 32'sh0064_0000;
	localparam logic signed [ANG_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [ANG_W-1:0] Q_MIN  = 32'sh8000_0000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

	logic                    in_valid       = 1'b0;
	logic                    in_ready;
	logic [AXIS_W-1:0]       axis           = '0;
	logic [MODE_W-1:0]       mode           = '0;
	logic signed [ANG_W-1:0] target_angle   = '0;
	logic signed [ANG_W-1:0] measured_angle = '0;
	logic signed [ANG_W-1:0] gain_p         = '0;
	logic signed [ANG_W-1:0] gain_i         = '0;
	logic signed [ANG_W-1:0] gain_d         = '0;

	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [CMD_W-1:0] motor_command;
	logic                    integrator_frozen;

	int fail_cnt;
	int pending;
	int cycle_cnt = 0;
	int burst_left = 0;

	// raised once by the stimulus, served once by the receiver
	bit long_hold_go = 1'b0;

	always #4 clk = ~clk;

	three_axis_pid_motor_drive_top i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.axis              (axis),
		.mode              (mode),
		.target_angle      (target_angle),
		.measured_angle    (measured_angle),
		.gain_p            (gain_p),
		.gain_i            (gain_i),
		.gain_d            (gain_d),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.motor_command     (motor_command),
		.integrator_frozen (integrator_frozen)
	);

	pid_drive_checker i_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.axis              (axis),
		.mode              (mode),
		.target_angle      (target_angle),
		.measured_angle    (measured_angle),
		.gain_p            (gain_p),
		.gain_i            (gain_i),
		.gain_d            (gain_d),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.motor_command     (motor_command),
		.integrator_frozen (integrator_frozen),
		.fail_cnt          (fail_cnt),
		.pending           (pending)
	);

	// watchdog: a hang or a lost result ends here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Config write: one register per cycle, sampled at the next edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Fill bits above the register width with noise; the block must mask them.
	function automatic logic [CFG_DATA_W-1:0] junk_above(input logic [CFG_DATA_W-1:0] v,
		input int w);
		logic [CFG_DATA_W-1:0] m;
		m = {CFG_DATA_W{1'b1}} << w;
		return (v & ~m) | (CFG_DATA_W'($urandom) & m);
	endfunction

	// Program every register; only called with the block idle.
	task automatic program_regs(input logic [CFG_DATA_W-1:0] c0, c1, c2, mx, mn, st, ds,
		input bit poke_unused);
		if (poke_unused)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		write_reg(REG_CLAMP0, c0);
		write_reg(REG_CLAMP1, c1);
		write_reg(REG_CLAMP2, c2);
		write_reg(REG_MAX_SPEED, mx);
		write_reg(REG_MIN_SPEED2, mn);
		write_reg(REG_INTEG_STEP, st);
		write_reg(REG_DERIV_SCALE, ds);
		cfg_we <= 1'b0;
	endtask

	// Offer one beat and hold it until taken. After the beat, the burst
	// counter decides whether a gap follows; valid is only lowered when the
	// gap is not empty, so it never drops and rises in one step.
	task automatic send_item(input logic [AXIS_W-1:0] ax, input logic [MODE_W-1:0] md,
		input logic signed [ANG_W-1:0] tgt, msr, kp, ki, kd);
		int gap;
		in_valid       <= 1'b1;
		axis           <= ax;
		mode           <= md;
		target_angle   <= tgt;
		measured_angle <= msr;
		gain_p         <= kp;
		gain_i         <= ki;
		gain_d         <= kd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every predicted beat has come back.
	// The first edge lets the checker log a beat taken at this very edge.
	task automatic drain_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly values within +-2^bits LSBs, now and then full range or a corner.
	function automatic logic signed [ANG_W-1:0] pick_q(input int bits);
		int span;
		int unsigned sel;
		logic signed [ANG_W-1:0] v;
		span = 1 << bits;
		sel = $urandom_range(0, 19);
		if (sel < 2)
			v = $urandom;
		else if (sel == 2) begin
			case ($urandom_range(0, 4))
				0:       v = Q_ZERO;
				1:       v = Q_LSB;
				2:       v = Q_MLSB;
				3:       v = Q_MAX;
				default: v = Q_MIN;
			endcase
		end else
			v = int'($urandom_range(0, 2 * span - 1)) - span;
		return v;
	endfunction

	// Random control requests. The axis is sticky so integral and freeze
	// history builds up; the measured angle often tracks the target closely
	// so errors hover around the clamp limits and the freeze flag toggles.
	task automatic run_random(input int n_items, input bit with_hold);
		int k;
		logic [AXIS_W-1:0] ax;
		logic [AXIS_W-1:0] ax_now;
		logic [MODE_W-1:0] md;
		logic signed [ANG_W-1:0] tgt;
		logic signed [ANG_W-1:0] msr;
		ax = AXIS_W'($urandom_range(0, AXES - 1));
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 9) < 3)
				ax = AXIS_W'($urandom_range(0, AXES - 1));
			ax_now = ($urandom_range(0, 31) == 0) ? AX_NONE : ax;
			md = MODE_W'($urandom_range(0, 3));
			tgt = pick_q($urandom_range(16, 24));
			if ($urandom_range(0, 1) == 1)
				msr = tgt - (int'($urandom_range(0, 2 << 20)) - (1 << 20));
			else
				msr = pick_q($urandom_range(16, 24));
			// receiver goes dark for a long stretch while we keep offering
			if (with_hold && k == n_items / 3)
				long_hold_go = 1'b1;
			// sender pause mid-phase until the pipe is empty
			if (k == n_items / 2)
				drain_results();
			send_item(ax_now, md, tgt, msr, pick_q($urandom_range(12, 20)),
				pick_q($urandom_range(10, 20)), pick_q($urandom_range(4, 14)));
		end
		drain_results();
	endtask

	// Receiver: segments of different stall styles, including stretches with
	// no stall at all, plus the one long hold-off counted here.
	initial begin : receiver
		int seg;
		int style;
		int period;
		int k;
		bit hold_taken;
		hold_taken = 1'b0;
		wait (arst_n);
		forever begin
			style  = $urandom_range(0, 3);
			seg    = $urandom_range(16, 160);
			period = $urandom_range(2, 6);
			for (k = 0; k < seg; k++) begin
				if (long_hold_go && !hold_taken) begin
					hold_taken = 1'b1;
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end else begin
					case (style)
						0:       out_ready <= 1'b1;
						1:       out_ready <= 1'($urandom_range(0, 1));
						2:       out_ready <= ($urandom_range(0, 7) != 0);
						default: out_ready <= (k % period == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, at reset register values ----
		// all zero: u = 0 with e = 0 is same-sign but not above the limit
		send_item(AX_0, MODE_P, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
		// plain P both signs of error
		send_item(AX_0, MODE_P, Q_TEN, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO);
		send_item(AX_0, MODE_P, Q_ZERO, Q_TEN, Q_ONE, Q_ZERO, Q_ZERO);
		// speed clipped to max_speed, axis freezes
		send_item(AX_1, MODE_PI, Q_FIVE, Q_ZERO, Q_100, Q_ONE, Q_ZERO);
		// frozen: integral neither updated nor used, then it thaws
		send_item(AX_1, MODE_PI, Q_FIVE, Q_ZERO, Q_ONE, Q_ONE, Q_ZERO);
		send_item(AX_1, MODE_PID, Q_FIVE, Q_ZERO, Q_ONE, Q_ONE, Q_ONE);
		// axis 2: small speed raised to the minimum; negative u
		send_item(AX_2, MODE_P, Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO);
		send_item(AX_2, MODE_PD, Q_ZERO, Q_TWO, Q_TWO, Q_ZERO, Q_HALF);
		// zero error with a derivative kick: zero counts as positive
		send_item(AX_2, MODE_PD, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ONE);
		// error saturation both ways, gain extremes, term saturation
		send_item(AX_0, MODE_PID, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
		send_item(AX_0, MODE_PID, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN);
		send_item(AX_1, MODE_PD, Q_MAX, Q_MIN, Q_ZERO, Q_ZERO, Q_MIN);
		// no such axis: zero result, no state touched
		send_item(AX_NONE, MODE_PID, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
		send_item(AX_NONE, MODE_P, $urandom, $urandom, $urandom, $urandom, $urandom);
		// one-LSB values: floor rounding of negative products
		send_item(AX_0, MODE_PI, Q_MLSB, Q_ZERO, Q_MLSB, Q_MLSB, Q_ZERO);
		send_item(AX_2, MODE_PID, Q_LSB, Q_ZERO, Q_MAX, Q_LSB, Q_LSB);
		send_item(AX_1, MODE_P, Q_ZERO, Q_ZERO, Q_MLSB, Q_MLSB, Q_MLSB);
		// freeze on axis 0 just above the limit, held, then released
		send_item(AX_0, MODE_PI, Q_40, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO);
		send_item(AX_0, MODE_PI, Q_40, Q_ZERO, Q_ONE, Q_ONE, Q_ZERO);
		send_item(AX_0, MODE_PI, Q_ONE, Q_ZERO, Q_ONE, Q_ONE, Q_ZERO);
		send_item(AX_0, MODE_PI, Q_ONE, Q_ZERO, Q_ONE, Q_ONE, Q_ZERO);
		drain_results();

		// ---- low extremes: no clamp, no speed, no step, no scale ----
		program_regs(junk_above(16'h0000, CLAMP_W), junk_above(16'h0000, CLAMP_W),
			junk_above(16'h0000, CLAMP_W), junk_above(16'h0000, SPEED_W),
			junk_above(16'h0000, SPEED_W), 16'h0000, 16'h0000, 1'b1);
		run_random(80, 1'b0);

		// ---- high extremes: min speed equals max, widest step and scale ----
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 1'b0);
		run_random(80, 1'b0);

		// ---- assorted settings, one phase with the long receiver hold ----
		for (p = 0; p < 5; p++) begin
			program_regs(
				junk_above(CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 32767) : $urandom_range(0, 400)), CLAMP_W),
				junk_above(CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 32767) : $urandom_range(0, 400)), CLAMP_W),
				junk_above(CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 32767) : $urandom_range(0, 400)), CLAMP_W),
				junk_above(CFG_DATA_W'($urandom), SPEED_W),
				junk_above(CFG_DATA_W'($urandom), SPEED_W),
				CFG_DATA_W'(($urandom_range(0, 1) == 1) ?
					$urandom_range(300, 2000) : $urandom_range(0, 65535)),
				CFG_DATA_W'(($urandom_range(0, 1) == 1) ?
					$urandom_range(0, 400) : $urandom_range(0, 65535)),
				(p == 2));
			run_random(150, (p == 1));
		end

		// everything is back; let the block settle before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
